### rtl/thermostat_keypad_display_controller_core_defines.svh
// ----------------------------------------------------------------------------
// Thermostat controller assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THERMOSTAT_KEYPAD_DISPLAY_CONTROLLER_CORE_DEFINES_SVH
`define THERMOSTAT_KEYPAD_DISPLAY_CONTROLLER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKDC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TKDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tkdc_pkg.sv
// ----------------------------------------------------------------------------
// Thermostat controller package
// Event codes, reset values, the 7-segment table and the word types.
// ----------------------------------------------------------------------------
package tkdc_pkg;

   typedef enum logic [2:0] {
      CMD_TEMP = 3'd0,
      CMD_EDIT = 3'd1,
      CMD_KEY  = 3'd2,
      CMD_UART = 3'd3,
      CMD_TICK = 3'd4
   } tkdc_cmd_type;

   localparam logic [7:0] UART_PANIC     = 8'h31;
   localparam logic [7:0] UART_GET_TEMP  = 8'h32;
   localparam logic [7:0] UART_GET_SETPT = 8'h33;

   localparam logic [3:0] BAND_RESET     = 4'd2;
   localparam logic [7:0] SETPOINT_RESET = 8'd88;
   localparam logic [3:0] KEY_WRAP       = 4'd11;

   localparam logic [7:0] SEG_TABLE [10] = '{
      8'hbf, 8'h86, 8'hdb, 8'hcf, 8'he6, 8'hed, 8'hfd, 8'h87, 8'hff, 8'he7
   };

   typedef struct packed {
      logic [2:0] cmd;
      logic [8:0] temp_sample;
      logic [1:0] key_row;
      logic [1:0] key_col;
      logic [7:0] uart_byte;
   } tkdc_req_type;

   typedef struct packed {
      logic       fan_on;
      logic       digit_units;
      logic [7:0] segments;
      logic       display_valid;
      logic       reply_valid;
      logic [8:0] reply_value;
   } tkdc_rsp_type;

   // Multiplying by 205/2048 gives the exact quotient for all 9-bit values.
   function automatic logic [5:0] div10(input logic [8:0] v);
      logic [16:0] p;
      p = 17'(v) * 17'd205;
      return p[16:11];
   endfunction

   function automatic logic [7:0] seg_of(input logic [5:0] d);
      if (d <= 6'd9) begin
         return SEG_TABLE[d[3:0]];
      end
      return 8'h00;
   endfunction

endpackage

### rtl/tkdc_engine.sv
// ----------------------------------------------------------------------------
// Thermostat controller event engine
// Holds the controller state and computes the result word of one event.
// ----------------------------------------------------------------------------
module tkdc_engine
   import tkdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [3:0]   csr_wr_data,
   input  logic         advance,
   input  tkdc_req_type req,
   output tkdc_rsp_type rsp
);

   logic [3:0] band_ff;
   logic [8:0] sensed_ff, sensed_in;
   logic [7:0] setpoint_ff, setpoint_in;
   logic [7:0] threshold_ff, threshold_in;
   logic [3:0] last_key_ff, last_key_in;
   logic       edit_ff, edit_in;
   logic       panic_ff, panic_in;
   logic       cooler_ff, cooler_in;
   logic       digit_sel_ff, digit_sel_in;

   logic [3:0]        key_raw;
   logic [3:0]        key;
   logic [8:0]        disp_value;
   logic [5:0]        tens;
   logic [8:0]        tens_times10;
   logic [3:0]        units;
   logic signed [9:0] temp_s;
   logic signed [9:0] thr_s;
   logic signed [9:0] low_s;

   always_comb begin
      key_raw = {1'b0, req.key_row, 1'b0} + {2'b00, req.key_row}
              + {2'b00, req.key_col} + 4'd1;
      key = (key_raw == KEY_WRAP) ? 4'd0 : key_raw;
      disp_value = edit_ff ? {1'b0, setpoint_ff} : sensed_ff;
      tens = div10(disp_value);
      tens_times10 = 9'({3'b000, tens} * 9'd10);
      units = 4'(disp_value - tens_times10);
   end

   always_comb begin
      sensed_in    = sensed_ff;
      setpoint_in  = setpoint_ff;
      threshold_in = threshold_ff;
      last_key_in  = last_key_ff;
      edit_in      = edit_ff;
      panic_in     = panic_ff;
      digit_sel_in = digit_sel_ff;
      rsp          = '0;
      unique case (req.cmd)
         CMD_TEMP: begin
            sensed_in = req.temp_sample;
         end
         CMD_EDIT: begin
            edit_in = !edit_ff;
            if (edit_ff) begin
               threshold_in = setpoint_ff;
            end
         end
         CMD_KEY: begin
            if (edit_ff) begin
               setpoint_in = 8'({4'b0000, last_key_ff} * 8'd10) + {4'b0000, key};
               last_key_in = key;
            end
         end
         CMD_UART: begin
            if (req.uart_byte == UART_PANIC) begin
               panic_in = 1'b1;
            end else if (req.uart_byte == UART_GET_TEMP) begin
               rsp.reply_valid = 1'b1;
               rsp.reply_value = sensed_ff;
            end else if (req.uart_byte == UART_GET_SETPT) begin
               rsp.reply_valid = 1'b1;
               rsp.reply_value = {1'b0, setpoint_ff};
            end else begin
               panic_in = 1'b0;
            end
         end
         CMD_TICK: begin
            rsp.display_valid = 1'b1;
            rsp.digit_units   = digit_sel_ff;
            rsp.segments      = digit_sel_ff ? seg_of({2'b00, units}) : seg_of(tens);
            digit_sel_in      = !digit_sel_ff;
         end
         default: begin
         end
      endcase

      temp_s = signed'({1'b0, sensed_in});
      thr_s  = signed'({2'b00, threshold_in});
      low_s  = thr_s - signed'({6'b000000, band_ff});
      if (panic_in || (temp_s > thr_s)) begin
         cooler_in = 1'b1;
      end else if (temp_s < low_s) begin
         cooler_in = 1'b0;
      end else begin
         cooler_in = cooler_ff;
      end
      rsp.fan_on = cooler_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff      <= BAND_RESET;
         sensed_ff    <= '0;
         setpoint_ff  <= SETPOINT_RESET;
         threshold_ff <= SETPOINT_RESET;
         last_key_ff  <= '0;
         edit_ff      <= 1'b0;
         panic_ff     <= 1'b0;
         cooler_ff    <= 1'b0;
         digit_sel_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            band_ff <= csr_wr_data;
         end
         if (advance) begin
            sensed_ff    <= sensed_in;
            setpoint_ff  <= setpoint_in;
            threshold_ff <= threshold_in;
            last_key_ff  <= last_key_in;
            edit_ff      <= edit_in;
            panic_ff     <= panic_in;
            cooler_ff    <= cooler_in;
            digit_sel_ff <= digit_sel_in;
         end
      end
   end

endmodule

### rtl/thermostat_keypad_display_controller_core.sv
// A result word is presented from the result register once its event word has
// passed the input register; a stalled result word can hold it there.
// Throughput: one event word per cycle when the result output does not stall; the
// input and result registers let a new word enter while a finished result waits to be taken.
// Reset is synchronous and active high; it clears all controller state to its
// power-on values (setpoint and threshold 88, band 2) and empties both stages.
// ----------------------------------------------------------------------------
// Thermostat controller core
// Cooling-fan thermostat with keypad entry, serial queries and a display.
// ----------------------------------------------------------------------------
module thermostat_keypad_display_controller_core
   import tkdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [8:0] req_temp_sample,
   input  logic [1:0] req_key_row,
   input  logic [1:0] req_key_col,
   input  logic [7:0] req_uart_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_fan_on,
   output logic       rsp_digit_units,
   output logic [7:0] rsp_segments,
   output logic       rsp_display_valid,
   output logic       rsp_reply_valid,
   output logic [8:0] rsp_reply_value
);

   tkdc_req_type req_ff;
   logic         req_valid_ff, req_valid_in;
   tkdc_rsp_type rsp_ff;
   tkdc_rsp_type rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         out_free;
   logic         advance;
   logic         accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign req_valid_in = accept || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   tkdc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .req         (req_ff),
      .rsp         (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= '{cmd: req_cmd, temp_sample: req_temp_sample, key_row: req_key_row,
                     key_col: req_key_col, uart_byte: req_uart_byte};
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fan_on        = rsp_ff.fan_on;
   assign rsp_digit_units   = rsp_ff.digit_units;
   assign rsp_segments      = rsp_ff.segments;
   assign rsp_display_valid = rsp_ff.display_valid;
   assign rsp_reply_valid   = rsp_ff.reply_valid;
   assign rsp_reply_value   = rsp_ff.reply_value;

endmodule

### rtl/tkdc_checker.sv
// ----------------------------------------------------------------------------
// Thermostat controller port checker
// Watches the core's ports and flags inconsistent result words and unexplained input stalls.
// ----------------------------------------------------------------------------
`include "thermostat_keypad_display_controller_core_defines.svh"

module tkdc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_fan_on,
   input logic       rsp_digit_units,
   input logic [7:0] rsp_segments,
   input logic       rsp_display_valid,
   input logic       rsp_reply_valid,
   input logic [8:0] rsp_reply_value
);

   `TKDC_ASSERT_SAME(a_one_kind, rsp_valid, !(rsp_display_valid && rsp_reply_valid),
      "result word is both display and reply")
   `TKDC_ASSERT_SAME(a_reply_zero, rsp_valid && !rsp_reply_valid, rsp_reply_value == 9'd0,
      "reply value set without a reply")
   `TKDC_ASSERT_SAME(a_display_zero, rsp_valid && !rsp_display_valid,
      (rsp_segments == 8'd0) && !rsp_digit_units, "display fields set without a tick")
   `TKDC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_segments) && $stable(rsp_fan_on) && $stable(rsp_reply_value),
      "stalled result word changed")
   `TKDC_ASSERT_SAME(a_stall_cause, req_stall, rsp_valid && rsp_stall,
      "input stalled without a stalled result word")

endmodule

bind thermostat_keypad_display_controller_core tkdc_checker u_checker (.*);
